// ----- sv/htn_pkg.sv -----
// Shared types and constants for the HTML text normalizer.
package htn_pkg;

  localparam int unsigned WINDOW = 16;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QUOT   = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       run_first;
    logic       run_last;
    logic       pre_mode;
    logic       space_before;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       run_done;
    logic       space_after;
  } out_item_t;

  // Window control from the sequencer.
  typedef struct packed {
    logic       append;
    logic       clear;
    logic       shift;
    logic [4:0] used;
  } win_ctl_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- sv/htn_window.sv -----
// Sixteen-byte lookahead window with append and variable shift.
module htn_window (
  input  logic                clk,
  input  logic                rst,
  input  htn_pkg::win_ctl_t   ctl,
  input  logic [7:0]          wr_byte,
  input  logic [3:0]          rd_idx,
  output logic [7:0]          head0,
  output logic [7:0]          head1,
  output logic [7:0]          rd_byte,
  output logic [4:0]          count
);

  logic [7:0] win [htn_pkg::WINDOW];
  logic [3:0] wr_idx;

  assign wr_idx  = ctl.clear ? 4'd0 : count[3:0];
  assign head0   = win[0];
  assign head1   = win[1];
  assign rd_byte = win[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 5'd0;
    end else if (ctl.append) begin
      count <= (ctl.clear ? 5'd0 : count) + 5'd1;
    end else if (ctl.shift) begin
      count <= count - ctl.used;
    end
  end

  always_ff @(posedge clk) begin
    logic [4:0] src;
    if (ctl.append) begin
      win[wr_idx] <= wr_byte;
    end else if (ctl.shift) begin
      for (int i = 0; i < htn_pkg::WINDOW; i++) begin
        src = 5'(i) + ctl.used;
        if (src < 5'(htn_pkg::WINDOW)) win[i] <= win[src[3:0]];
      end
    end
  end

endmodule

// ----- sv/htn_entity.sv -----
// Entity accumulator: one name byte per step, named and numeric forms.
module htn_entity (
  input  logic       clk,
  input  logic       clear,
  input  logic       step,
  input  logic [7:0] b,
  input  logic [3:0] pos,
  output logic       hit,
  output logic [7:0] value
);

  logic m_amp, m_lt, m_gt, m_quot, m_apos, m_h39, m_nbsp;
  logic is_num, hex, bad;
  logic [8:0]  acc;
  logic [4:0]  dig;
  logic [12:0] prod;
  logic [12:0] sum;
  logic        named;

  function automatic logic name_hit(logic [31:0] s, logic [2:0] len,
                                    logic [3:0] i, logic [7:0] c);
    return ({1'b0, i} < {2'b0, len}) && (c == s[31 - 8 * i[1:0] -: 8]);
  endfunction

  function automatic logic [4:0] digit_of(logic [7:0] c, logic h);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (h && c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (h && c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  assign dig  = digit_of(b, hex);
  assign prod = hex ? {acc, 4'b0} : ({1'b0, acc, 3'b0} + {3'b0, acc, 1'b0});
  assign sum  = prod + {9'd0, dig[3:0]};

  always_ff @(posedge clk) begin
    if (clear) begin
      {m_amp, m_lt, m_gt, m_quot, m_apos, m_h39, m_nbsp} <= '1;
      is_num <= 1'b0;
      hex    <= 1'b0;
      bad    <= 1'b0;
      acc    <= 9'd0;
    end else if (step) begin
      m_amp  <= m_amp  && name_hit(32'h616d7000, 3'd3, pos, b);
      m_lt   <= m_lt   && name_hit(32'h6c740000, 3'd2, pos, b);
      m_gt   <= m_gt   && name_hit(32'h67740000, 3'd2, pos, b);
      m_quot <= m_quot && name_hit(32'h71756f74, 3'd4, pos, b);
      m_apos <= m_apos && name_hit(32'h61706f73, 3'd4, pos, b);
      m_h39  <= m_h39  && name_hit(32'h23333900, 3'd3, pos, b);
      m_nbsp <= m_nbsp && name_hit(32'h6e627370, 3'd4, pos, b);
      if (pos == 4'd0) begin
        is_num <= (b == htn_pkg::CH_HASH);
      end else if (pos == 4'd1 && (b == 8'h78 || b == 8'h58)) begin
        hex <= 1'b1;
      end else if (is_num && !bad) begin
        if (!dig[4]) bad <= 1'b1;
        else if (sum > 13'd255) acc <= 9'd256;
        else acc <= sum[8:0];
      end
    end
  end

  // Resolve with the name length equal to the position of the ';'.
  always_comb begin
    named = 1'b1;
    value = htn_pkg::CH_QMARK;
    if (m_amp && pos == 4'd3) value = htn_pkg::CH_AMP;
    else if (m_lt && pos == 4'd2) value = htn_pkg::CH_LT;
    else if (m_gt && pos == 4'd2) value = htn_pkg::CH_GT;
    else if (m_quot && pos == 4'd4) value = htn_pkg::CH_QUOT;
    else if ((m_apos && pos == 4'd4) || (m_h39 && pos == 4'd3)) value = htn_pkg::CH_APOS;
    else if (m_nbsp && pos == 4'd4) value = htn_pkg::CH_SPACE;
    else begin
      named = 1'b0;
      value = (bad || acc[8]) ? htn_pkg::CH_QMARK : acc[7:0];
    end
    hit = named || (is_num && pos != 4'd0);
  end

endmodule

// ----- sv/html_text_normalizer.sv -----
// Top level: lookahead window, decode sequencer and output register.
// Latency: a byte waits in the window until 16 are held or the run ends.
// An accepted byte passes IDLE and CHECK when nothing is decoded. A plain unit adds DECODE, EMIT,
// EMIT_CH, SHIFT, CHECK, plus EMIT_SP before EMIT_CH for a space in front, no EMIT_CH when it collapses;
// an entity adds a SCAN step per byte up to the ';'; results wait for the output; new bytes wait for IDLE.
// Reset (rst, synchronous): window empty, mode and pending space cleared.
module html_text_normalizer #(
  parameter int OUT_CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  htn_pkg::in_item_t    src_item,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output htn_pkg::out_item_t   dst_item
);

  localparam logic [10:0] LIMIT = 11'(OUT_CAPACITY - 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_EMIT    = 4'd4;
  localparam logic [3:0] S_EMIT_SP = 4'd5;
  localparam logic [3:0] S_EMIT_CH = 4'd6;
  localparam logic [3:0] S_SHIFT   = 4'd7;
  localparam logic [3:0] S_CLOSE   = 4'd8;

  logic [3:0]  state;
  logic        last_r, pre_l, space_l, space_seen;
  logic [10:0] emitted;
  logic [4:0]  k;
  logic [7:0]  ch;
  logic [4:0]  used;

  htn_pkg::win_ctl_t wctl;
  logic [7:0] head0, head1, rd_byte;
  logic [4:0] count;
  logic       ent_hit, ent_step, slot_free, sp_end, is_semi;
  logic [7:0] ent_val, ch_out;

  assign src_ready = (state == S_IDLE);
  assign slot_free = !dst_valid || dst_ready;
  assign is_semi   = (rd_byte == htn_pkg::CH_SEMI);
  assign ent_step  = (state == S_SCAN) && (k < count) && !is_semi;
  assign sp_end    = pre_l ? space_l : space_seen;
  // Preformatted text turns CR into LF.
  assign ch_out    = (ch == htn_pkg::CH_CR) ? htn_pkg::CH_LF : ch;

  always_comb begin
    wctl.append = src_valid && src_ready;
    wctl.clear  = src_valid && src_ready && src_item.run_first;
    wctl.shift  = (state == S_SHIFT);
    wctl.used   = used;
  end

  htn_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (wctl),
    .wr_byte (src_item.byte_in),
    .rd_idx  (k[3:0]),
    .head0   (head0),
    .head1   (head1),
    .rd_byte (rd_byte),
    .count   (count)
  );

  htn_entity u_entity (
    .clk   (clk),
    .clear (state == S_DECODE),
    .step  (ent_step),
    .b     (rd_byte),
    .pos   (k[3:0] - 4'd1),
    .hit   (ent_hit),
    .value (ent_val)
  );

  // Sequencer: decode one unit from the window head per pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_r     <= 1'b0;
      pre_l      <= 1'b0;
      space_l    <= 1'b0;
      space_seen <= 1'b0;
      emitted    <= 11'd0;
      k          <= 5'd0;
      ch         <= 8'd0;
      used       <= 5'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (src_valid) begin
            // First byte latches mode and carried space, restarts the count.
            if (src_item.run_first) begin
              pre_l      <= src_item.pre_mode;
              space_l    <= src_item.space_before;
              space_seen <= src_item.pre_mode ? 1'b0 : src_item.space_before;
              emitted    <= 11'd0;
            end
            last_r <= src_item.run_last;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Decode on a full window, or drain after the last byte.
          if (count == 5'(htn_pkg::WINDOW) || (last_r && count != 5'd0)) state <= S_DECODE;
          else if (last_r) state <= S_CLOSE;
          else state <= S_IDLE;
        end
        S_DECODE: begin
          if (emitted >= LIMIT) begin
            // Output full: drop the rest of the window.
            used  <= count;
            state <= S_SHIFT;
          end else if (head0 == htn_pkg::CH_AMP) begin
            k     <= 5'd1;
            state <= S_SCAN;
          end else if (head0[7]) begin
            state <= S_EMIT;
            ch    <= htn_pkg::CH_QMARK;
            used  <= 5'd1;
            if (count >= 5'd2 && head0[7:5] == 3'b110 && head1[7:6] == 2'b10) begin
              used <= 5'd2;
              if (head0[4:2] == 3'b000) ch <= {head0[1:0], head1[5:0]};
            end else if (count >= 5'd3 && head0[7:4] == 4'b1110) begin
              used <= 5'd3;
            end else if (count >= 5'd4 && head0[7:3] == 5'b11110) begin
              used <= 5'd4;
            end
          end else begin
            ch    <= head0;
            used  <= 5'd1;
            state <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (k >= count) begin
            // No terminator in the window: '&' stands as a plain byte.
            ch    <= htn_pkg::CH_AMP;
            used  <= 5'd1;
            state <= S_EMIT;
          end else if (is_semi) begin
            ch    <= ent_hit ? ent_val : htn_pkg::CH_AMP;
            used  <= ent_hit ? k + 5'd1 : 5'd1;
            state <= S_EMIT;
          end else begin
            k <= k + 5'd1;
          end
        end
        S_EMIT: begin
          if (!pre_l && htn_pkg::is_ws(ch)) begin
            space_seen <= 1'b1;
            state      <= S_SHIFT;
          end else if (!pre_l && space_seen) begin
            // Space plus character must both fit, else mark the output full.
            if ({1'b0, emitted} + 12'd2 <= {1'b0, LIMIT}) begin
              state <= S_EMIT_SP;
            end else begin
              emitted <= LIMIT;
              state   <= S_SHIFT;
            end
          end else begin
            state <= S_EMIT_CH;
          end
        end
        S_EMIT_SP: begin
          if (slot_free) begin
            emitted    <= emitted + 11'd1;
            space_seen <= 1'b0;
            state      <= S_EMIT_CH;
          end
        end
        S_EMIT_CH: begin
          if (slot_free) begin
            emitted    <= emitted + 11'd1;
            space_seen <= 1'b0;
            state      <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          state <= S_CHECK;
        end
        S_CLOSE: begin
          if (slot_free) begin
            space_l    <= sp_end;
            space_seen <= pre_l ? 1'b0 : sp_end;
            emitted    <= 11'd0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load when free or being taken, else hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (slot_free &&
                 (state == S_EMIT_SP || state == S_EMIT_CH || state == S_CLOSE)) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == S_EMIT_SP) begin
        dst_item <= '{char_out: htn_pkg::CH_SPACE, char_valid: 1'b1,
                      run_done: 1'b0, space_after: 1'b0};
      end else if (state == S_EMIT_CH) begin
        dst_item <= '{char_out: ch_out, char_valid: 1'b1,
                      run_done: 1'b0, space_after: 1'b0};
      end else if (state == S_CLOSE) begin
        dst_item <= '{char_out: 8'd0, char_valid: 1'b0,
                      run_done: 1'b1, space_after: sp_end};
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 5'(htn_pkg::WINDOW))
    else $error("window count above window size");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emitted <= LIMIT)
    else $error("emitted count above limit");

  a_close_kind: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.run_done |-> !dst_item.char_valid)
    else $error("closing result carries a character");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOSE) |-> (count == 5'd0))
    else $error("run closed with bytes left in window");

endmodule
